>>> design/cso_pkg.sv
// shared constants, types and controller/datapath interface structs for the site counter
package cso_pkg;

   localparam int SLOT_W      = 10;
   localparam int TABLE_SLOTS = 1 << SLOT_W;
   localparam int HALF_SLOTS  = TABLE_SLOTS / 2;
   localparam int DATA_W      = 32;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [SLOT_W:0]   occ_type;
   typedef logic [DATA_W-1:0] word_type;

   typedef struct packed {
      logic     valid;
      word_type key;
      word_type count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic step;
      logic insert;
      logic update;
      logic reject;
   } cso_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic empty;
      logic hit;
      logic half_full;
      logic out_free;
   } cso_status_type;

endpackage

>>> design/cso_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module cso_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/cso_ctrl.sv
// controller state machine: clearing pass, idle, probe walk
module cso_ctrl
   import cso_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  cso_status_type status,
   output cso_cmd_type    cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_PROBE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (!status.empty && !status.hit) begin
               cmd.step = 1'b1;
            end else if (status.out_free) begin
               // finish only when the output register can take the result
               cmd.update = status.hit;
               cmd.insert = status.empty && !status.half_full;
               cmd.reject = status.empty && status.half_full;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

>>> design/cso_dp.sv
// datapath: slot table ram, probe pointer, occupancy, count update and result register
module cso_dp
   import cso_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  word_type       req_site_id,
   input  word_type       req_prior_order,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output word_type       rsp_occurrence_count,
   output word_type       rsp_new_order,
   output logic           rsp_table_full,
   input  cso_cmd_type    cmd,
   output cso_status_type status
);

   slot_type  slot_ff, slot_in;
   slot_type  clr_ff;
   occ_type   occ_ff;
   word_type  id_ff, prior_ff;
   logic      rsp_valid_ff;
   word_type  count_ff, order_ff;
   logic      full_ff;

   slot_type               rd_addr;
   logic                   wr_en;
   slot_type               wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic [ENTRY_W-1:0]     rd_data;
   entry_type              entry;
   entry_type              new_entry;
   word_type               base;
   word_type               count_inc;
   word_type               sum;
   word_type               new_count;
   word_type               new_order;
   logic                   prior_zero;
   logic                   finish;

   cso_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // probe pointer; the read port follows it so each probe cycle sees its slot
   always_comb begin
      slot_in = slot_ff;
      if (cmd.accept) begin
         slot_in = req_site_id[SLOT_W-1:0];
      end else if (cmd.step) begin
         slot_in = slot_type'(slot_ff + 1'b1);
      end
      rd_addr = slot_in;
   end

   assign entry = entry_type'(rd_data);

   assign status.clear_last = (clr_ff == slot_type'(TABLE_SLOTS - 1));
   assign status.empty      = !entry.valid;
   assign status.hit        = entry.valid && (entry.key == id_ff);
   assign status.half_full  = (occ_ff >= occ_type'(HALF_SLOTS));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // a new site starts from zero, a known one from its stored count
   assign base       = status.hit ? entry.count : '0;
   assign prior_zero = (prior_ff == '0);
   assign count_inc  = base + word_type'(1);
   assign sum        = prior_ff + base;
   assign new_count  = prior_zero ? count_inc : base;
   assign new_order  = prior_zero ? count_inc : sum;

   always_comb begin
      new_entry.valid = 1'b1;
      new_entry.key   = id_ff;
      new_entry.count = new_count;
      wr_en   = 1'b0;
      wr_addr = slot_ff;
      wr_data = new_entry;
      if (cmd.clear_wr) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (cmd.insert || cmd.update) begin
         wr_en = 1'b1;
      end
   end

   assign finish = cmd.insert || cmd.update || cmd.reject;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_wr) begin
            clr_ff <= slot_type'(clr_ff + 1'b1);
         end
         if (cmd.insert) begin
            occ_ff <= occ_type'(occ_ff + 1'b1);
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (cmd.accept) begin
         id_ff    <= req_site_id;
         prior_ff <= req_prior_order;
      end
      if (cmd.reject) begin
         count_ff <= '0;
         order_ff <= prior_ff;
         full_ff  <= 1'b1;
      end else if (cmd.insert || cmd.update) begin
         count_ff <= new_count;
         order_ff <= new_order;
         full_ff  <= 1'b0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_occurrence_count = count_ff;
   assign rsp_new_order        = order_ff;
   assign rsp_table_full       = full_ff;

endmodule

>>> design/compare_site_occurrence_counter_top.sv
// Compare-site occurrence counter: a 1024-slot open-addressed table with linear
// probing keyed by site id, one result transaction per request transaction. After
// reset the block runs a clearing pass over the slot ram with req_stall high. An
// accepted request then walks the probe, one ram read per cycle starting at
// site_id modulo 1024, until it meets its key or an empty slot, with req_stall high
// until the walk is over. A result waiting in the output register does not block
// the next request, but that request holds in its last probe cycle until the output
// register is free. Once 512 sites are stored, a new site gets table_full with count
// zero and new_order equal to prior_order; known sites keep counting.
module compare_site_occurrence_counter_top
   import cso_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  word_type req_site_id,
   input  word_type req_prior_order,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output word_type rsp_occurrence_count,
   output word_type rsp_new_order,
   output logic     rsp_table_full
);

   cso_cmd_type    cmd;
   cso_status_type status;

   cso_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cso_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_site_id          (req_site_id),
      .req_prior_order      (req_prior_order),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_occurrence_count (rsp_occurrence_count),
      .rsp_new_order        (rsp_new_order),
      .rsp_table_full       (rsp_table_full),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

>>> design/cso_checker.sv
// port-level checker for the site counter, bound to the top level
module cso_checker
   import cso_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_stall,
   input word_type req_site_id,
   input word_type req_prior_order,
   input logic     rsp_valid,
   input logic     rsp_stall,
   input word_type rsp_occurrence_count,
   input word_type rsp_new_order,
   input logic     rsp_table_full
);

   logic       req_acc;
   logic       rsp_acc;
   logic [1:0] pend_ff;
   logic [1:0] pend_in;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // transactions accepted but not yet answered
   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = 2'(pend_ff + 2'd1);
      end else if (!req_acc && rsp_acc) begin
         pend_in = 2'(pend_ff - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request side open right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall)
      else $error("second request accepted while the first is in the probe walk");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result offered with no request outstanding");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests outstanding");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_occurrence_count)
         && $stable(rsp_new_order) && $stable(rsp_table_full))
      else $error("stalled result changed");

endmodule

bind compare_site_occurrence_counter_top cso_checker u_checker (.*);
